// ===== rtl/cpct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpct_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIFF,
    S_PREP,
    S_SQX,
    S_SQY,
    S_SQL,
    S_CMP,
    S_DONE
  } state_t;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  localparam logic ACT_TEST  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/collision_pair_contact_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Collider pair contact tracker. Each input transfer either tests one pair of 2D colliders
// (box or circle each) for overlap or clears every contact bit. The block keeps one contact
// bit per pair key in a RAM of 2^(2*ID_BITS) entries and returns one result per transfer:
// enter, stay, exit or none, plus the overlap bit. Squares go through one shared multiplier
// under a small sequencer: a circle test steps through DIFF, PREP, SQX, SQY, SQL, CMP and DONE,
// a box-box test through DIFF, PREP and DONE, and the next input is taken only once the
// sequencer is back in IDLE. A clear sweeps the RAM one entry a cycle. After reset the same
// sweep runs with in_stall high throughout.
// A finished result sits in the output register, so a new item is taken while it waits.

module collision_pair_contact_tracker_top #(
  parameter int ID_BITS    = 6,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_action,
  input  wire logic [2*ID_BITS-1:0]         in_pair_key,
  input  wire logic                         in_first_kind,
  input  wire logic                         in_second_kind,
  input  wire logic signed [COORD_BITS-1:0] in_first_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_y,
  input  wire logic signed [COORD_BITS-1:0] in_second_x,
  input  wire logic signed [COORD_BITS-1:0] in_second_y,
  input  wire logic [COORD_BITS-2:0]        in_first_extent_a,
  input  wire logic [COORD_BITS-2:0]        in_first_extent_b,
  input  wire logic [COORD_BITS-2:0]        in_second_extent_a,
  input  wire logic [COORD_BITS-2:0]        in_second_extent_b,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_event_res,
  output logic                              out_touching
);

  localparam int KEY_BITS  = 2 * ID_BITS;
  localparam int EXT_BITS  = COORD_BITS - 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int OPW       = COORD_BITS + 2;
  localparam int PRODW     = 2 * OPW;
  localparam int ACCW      = PRODW + 1;

  cpct_pkg::state_t state_r, state_nxt;
  logic [KEY_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                clr_op_r, clr_op_nxt;
  logic                out_valid_r, out_valid_nxt;

  // captured item
  logic                         action_r;
  logic [KEY_BITS-1:0]          key_r;
  logic                         k1_r, k2_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [EXT_BITS-1:0]          a1_r, b1_r, a2_r, b2_r;

  // datapath
  logic signed [DIFF_BITS-1:0] dx_r, dy_r;
  logic [OPW-1:0]              opx_r, opy_r, opx_nxt, opy_nxt;
  logic [COORD_BITS-1:0]       lim_r, lim_nxt;
  logic [PRODW-1:0]            prod_r;
  logic [ACCW-1:0]             acc_r;
  logic                        hit_r, hit_nxt;
  logic [1:0]                  ev_r, ev_nxt;
  logic                        touch_r;

  logic                  in_xfer;
  logic                  out_load;
  logic [OPW-1:0]        sq_op;
  logic [DIFF_BITS-1:0]  ax, ay;
  logic [OPW-1:0]        ax2, ay2;
  logic [COORD_BITS-1:0] sum_a, sum_b;
  logic [EXT_BITS-1:0]   r_sel, w_sel, h_sel;
  logic                  ram_we;
  logic [KEY_BITS-1:0]   ram_waddr;
  logic                  ram_wdata;
  logic                  prev_bit;

  assign in_stall      = (state_r != cpct_pkg::S_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_touching  = touch_r;

  cpct_ram #(
    .WIDTH     (1),
    .ADDR_BITS (KEY_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (in_pair_key),
    .rdata (prev_bit)
  );

  // geometry operands
  always_comb begin
    ax    = dx_r[DIFF_BITS-1] ? DIFF_BITS'(~dx_r + 1'b1) : DIFF_BITS'(dx_r);
    ay    = dy_r[DIFF_BITS-1] ? DIFF_BITS'(~dy_r + 1'b1) : DIFF_BITS'(dy_r);
    ax2   = {ax, 1'b0};
    ay2   = {ay, 1'b0};
    sum_a = COORD_BITS'({1'b0, a1_r} + {1'b0, a2_r});
    sum_b = COORD_BITS'({1'b0, b1_r} + {1'b0, b2_r});
    if (k1_r == cpct_pkg::KIND_CIRCLE) begin
      r_sel = a1_r;
      w_sel = a2_r;
      h_sel = b2_r;
    end else begin
      r_sel = a2_r;
      w_sel = a1_r;
      h_sel = b1_r;
    end
    if (k1_r == cpct_pkg::KIND_CIRCLE && k2_r == cpct_pkg::KIND_CIRCLE) begin
      opx_nxt = OPW'(ax);
      opy_nxt = OPW'(ay);
      lim_nxt = sum_a;
    end else begin
      opx_nxt = (ax2 > OPW'(w_sel)) ? ax2 - OPW'(w_sel) : '0;
      opy_nxt = (ay2 > OPW'(h_sel)) ? ay2 - OPW'(h_sel) : '0;
      lim_nxt = {r_sel, 1'b0};
    end
  end

  // shared squaring unit operand
  always_comb begin
    unique case (state_r)
      cpct_pkg::S_SQX: sq_op = opx_r;
      cpct_pkg::S_SQY: sq_op = opy_r;
      default:         sq_op = OPW'(lim_r);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_op_nxt    = clr_op_r;
    hit_nxt       = hit_r;
    ev_nxt        = ev_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = key_r;
    ram_wdata     = hit_r;
    unique case (state_r)
      cpct_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_action == cpct_pkg::ACT_CLEAR) begin
            state_nxt   = cpct_pkg::S_CLEAR;
            clr_cnt_nxt = '0;
            clr_op_nxt  = 1'b1;
          end else begin
            state_nxt  = cpct_pkg::S_DIFF;
            clr_op_nxt = 1'b0;
          end
        end
      end
      cpct_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = clr_op_r ? cpct_pkg::S_DONE : cpct_pkg::S_IDLE;
        end
      end
      cpct_pkg::S_DIFF: begin
        state_nxt = cpct_pkg::S_PREP;
      end
      cpct_pkg::S_PREP: begin
        if (k1_r == cpct_pkg::KIND_BOX && k2_r == cpct_pkg::KIND_BOX) begin
          hit_nxt   = (ax2 < OPW'(sum_a)) && (ay2 < OPW'(sum_b));
          state_nxt = cpct_pkg::S_DONE;
        end else begin
          state_nxt = cpct_pkg::S_SQX;
        end
      end
      cpct_pkg::S_SQX: begin
        state_nxt = cpct_pkg::S_SQY;
      end
      cpct_pkg::S_SQY: begin
        state_nxt = cpct_pkg::S_SQL;
      end
      cpct_pkg::S_SQL: begin
        state_nxt = cpct_pkg::S_CMP;
      end
      cpct_pkg::S_CMP: begin
        hit_nxt   = (acc_r <= ACCW'(prod_r));
        state_nxt = cpct_pkg::S_DONE;
      end
      cpct_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cpct_pkg::S_IDLE;
          if (clr_op_r) begin
            ev_nxt = cpct_pkg::EV_NONE;
          end else begin
            ram_we = 1'b1;
            if (hit_r) begin
              ev_nxt = prev_bit ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
            end else begin
              ev_nxt = prev_bit ? cpct_pkg::EV_EXIT : cpct_pkg::EV_NONE;
            end
          end
        end
      end
      default: begin
        state_nxt = cpct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpct_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_r <= in_action;
      key_r    <= in_pair_key;
      k1_r     <= in_first_kind;
      k2_r     <= in_second_kind;
      x1_r     <= in_first_x;
      y1_r     <= in_first_y;
      x2_r     <= in_second_x;
      y2_r     <= in_second_y;
      a1_r     <= in_first_extent_a;
      b1_r     <= in_first_extent_b;
      a2_r     <= in_second_extent_a;
      b2_r     <= in_second_extent_b;
    end
    if (state_r == cpct_pkg::S_DIFF) begin
      dx_r <= DIFF_BITS'(x2_r) - DIFF_BITS'(x1_r);
      dy_r <= DIFF_BITS'(y2_r) - DIFF_BITS'(y1_r);
    end
    if (state_r == cpct_pkg::S_PREP) begin
      opx_r <= opx_nxt;
      opy_r <= opy_nxt;
      lim_r <= lim_nxt;
    end
    prod_r <= sq_op * sq_op;
    if (state_r == cpct_pkg::S_SQY) begin
      acc_r <= ACCW'(prod_r);
    end else if (state_r == cpct_pkg::S_SQL) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
    hit_r <= hit_nxt;
    ev_r  <= ev_nxt;
    if (out_load) begin
      touch_r <= hit_r && !clr_op_r && (action_r == cpct_pkg::ACT_TEST);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpct_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpct_ram #(
  parameter int WIDTH     = 1,
  parameter int ADDR_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
